### rtl/ssr_pkg.sv
// Shared types and constants for the stream substring replace block.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package ssr_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_BYTES  = 2'd3;

    // One result item as it travels from the control logic to the output buffer.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              last;
    } ssr_result_t;

endpackage

`default_nettype wire

### rtl/ssr_cell.sv
// One cell of the search window: holds one byte and compares it with its pattern byte.
// Depends on ssr_pkg for the byte width.
`default_nettype none

module ssr_cell
    import ssr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              shift,
    input  wire logic              load,
    input  wire logic [BYTE_W-1:0] din,
    input  wire logic [BYTE_W-1:0] nbr,
    input  wire logic [BYTE_W-1:0] pat,
    output logic      [BYTE_W-1:0] dout,
    output logic                   eq_held,
    output logic                   eq_in
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // A load takes the incoming byte; a shift takes the younger neighbor's byte.
    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = din;
        end
        else if (shift)
        begin
            byte_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign dout    = byte_reg;
    assign eq_held = (byte_reg == pat);
    assign eq_in   = (din == pat);

endmodule

`default_nettype wire

### rtl/ssr_out_buf.sv
// Two-entry output buffer that decouples result production from the output stall.
// Depends on ssr_pkg for the result struct.
`default_nettype none

module ssr_out_buf
    import ssr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ssr_result_t push_data,
    output logic             space,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ssr_result_t      out_data
);

    ssr_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/stream_substring_replace_unit.sv
// Top level of the streaming substring search-and-replace block.
// Depends on ssr_pkg, ssr_cell and ssr_out_buf.
`default_nettype none

// Usage
// -----
// Source bytes enter one item at a time on the input channel (in_valid, in_stall,
// in_byte, in_last); rewritten bytes leave on the output channel (out_valid, out_stall,
// out_byte, byte_valid, out_last). Every leftmost, non-overlapping occurrence of the
// configured pattern is replaced by the configured replacement, which may be empty.
// The pattern window is a row of byte cells that compare themselves with the pattern
// in parallel, so a match is found in the cycle the completing byte arrives.
// An item that yields at most one result does not stall the input, and items may
// follow back to back while the buffer has space. An item that yields n results
// (a replacement of n bytes, or the flush of the window on the final byte) holds
// the input stalled while the rest go out, one per cycle when the buffer has space.
// Results leave through a two-entry buffer, so each result is registered before it
// reaches the output, and an item can be accepted while an earlier result still waits.
// If the string ends with no byte produced, one result with byte_valid low and
// out_last high marks the end. Reset empties the window and the buffer and loads
// the register defaults (pattern length one, everything else zero). While the
// receiver stalls, results queue in the buffer; once it is full the input stalls.
// Registers are written through cfg_write, cfg_index and cfg_data.

module stream_substring_replace_unit
    import ssr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BYTE_W-1:0]      in_byte,
    input  wire logic                   in_last,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [BYTE_W-1:0]      out_byte,
    output logic                        byte_valid,
    output logic                        out_last
);

    // Window count covers 0..PATTERN_MAX; replacement count covers 0..REPLACE_MAX.
    localparam int CW   = $clog2(PATTERN_MAX + 1);
    localparam int RW   = $clog2(REPLACE_MAX + 1);
    localparam int RIDX = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_REP   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    // Configuration registers.
    logic [3:0]            pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [3:0]            replace_length_reg;
    logic [CFG_DATA_W-1:0] replace_bytes_reg;

    // Control state.
    logic [1:0]      mode_reg;
    logic [1:0]      mode_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [RIDX-1:0] rep_idx_reg;
    logic [RIDX-1:0] rep_idx_next;
    logic [RW-1:0]   rep_left_reg;
    logic [RW-1:0]   rep_left_next;
    logic            rep_last_reg;
    logic            rep_last_next;

    // Effective lengths after clamping.
    logic [CW-1:0] plen_eff;
    logic [RW-1:0] rlen_eff;

    logic [BYTE_W-1:0] rep_arr [REPLACE_MAX];

    // Cell row.
    logic [BYTE_W-1:0]      cell_q [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq_held;
    logic [PATTERN_MAX-1:0] eq_in;
    logic [PATTERN_MAX-1:0] cell_load;
    logic                   cell_shift;

    logic          accept;
    logic          space;
    logic [CW-1:0] newcount;
    logic          hit;
    logic          is_match;
    logic          do_pop;
    logic [BYTE_W-1:0] oldest;

    logic        push;
    ssr_result_t push_data;
    ssr_result_t out_data;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= 4'd1;
            pattern_bytes_reg  <= '0;
            replace_length_reg <= 4'd0;
            replace_bytes_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[3:0];
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                CFG_REPLACE_LENGTH: replace_length_reg <= cfg_data[3:0];
                CFG_REPLACE_BYTES:  replace_bytes_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // A pattern length of zero acts as one; longer lengths saturate at the window size.
    always_comb
    begin
        if (pattern_length_reg == 4'd0)
        begin
            plen_eff = CW'(1);
        end
        else if (pattern_length_reg > 4'(PATTERN_MAX))
        begin
            plen_eff = CW'(PATTERN_MAX);
        end
        else
        begin
            plen_eff = CW'(pattern_length_reg);
        end
        if (replace_length_reg > 4'(REPLACE_MAX))
        begin
            rlen_eff = RW'(REPLACE_MAX);
        end
        else
        begin
            rlen_eff = RW'(replace_length_reg);
        end
    end

    generate
        for (genvar r = 0; r < REPLACE_MAX; r++)
        begin : g_rep
            assign rep_arr[r] = replace_bytes_reg[BYTE_W*r +: BYTE_W];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Window cells: cell 0 holds the oldest byte. A shift moves every byte one
    // place toward cell 0; the incoming byte is loaded at the first free place.
    // ------------------------------------------------------------------
    generate
        for (genvar k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [BYTE_W-1:0] nbr;
            if (k == PATTERN_MAX - 1)
            begin : g_end
                assign nbr = in_byte;
            end
            else
            begin : g_mid
                assign nbr = cell_q[k+1];
            end

            ssr_cell u_cell (
                .clk     (clk),
                .shift   (cell_shift),
                .load    (cell_load[k]),
                .din     (in_byte),
                .nbr     (nbr),
                .pat     (pattern_bytes_reg[BYTE_W*k +: BYTE_W]),
                .dout    (cell_q[k]),
                .eq_held (eq_held[k]),
                .eq_in   (eq_in[k])
            );
        end
    endgenerate

    assign in_stall = (mode_reg != MODE_IDLE) || !space;
    assign accept   = in_valid && !in_stall;
    assign newcount = count_reg + CW'(1);
    assign oldest   = (count_reg == '0) ? in_byte : cell_q[0];

    // The window after the push matches when the held bytes and the incoming byte
    // in the next free place all agree with the pattern and the length is exact.
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (CW'(k) < count_reg)
            begin
                hit = hit && eq_held[k];
            end
            else if (CW'(k) == count_reg)
            begin
                hit = hit && eq_in[k];
            end
        end
    end

    assign is_match = (newcount == plen_eff) && hit;
    assign do_pop   = !is_match && ((newcount >= plen_eff) || in_last);

    // ------------------------------------------------------------------
    // Control: emits at most one result per cycle into the output buffer.
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        rep_idx_next  = rep_idx_reg;
        rep_left_next = rep_left_reg;
        rep_last_next = rep_last_reg;
        push          = 1'b0;
        push_data     = '{data: '0, byte_valid: 1'b1, last: 1'b0};
        cell_shift    = 1'b0;
        cell_load     = '0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (accept)
                begin
                    if (is_match)
                    begin
                        count_next = '0;
                        if (rlen_eff != '0)
                        begin
                            push           = 1'b1;
                            push_data.data = rep_arr[0];
                            push_data.last = in_last && (rlen_eff == RW'(1));
                            if (rlen_eff != RW'(1))
                            begin
                                mode_next     = MODE_REP;
                                rep_idx_next  = RIDX'(1);
                                rep_left_next = rlen_eff - RW'(1);
                                rep_last_next = in_last;
                            end
                        end
                        else if (in_last)
                        begin
                            // Empty replacement at the end: a bare end marker.
                            push                 = 1'b1;
                            push_data.byte_valid = 1'b0;
                            push_data.last       = 1'b1;
                        end
                    end
                    else if (do_pop)
                    begin
                        push           = 1'b1;
                        push_data.data = oldest;
                        push_data.last = in_last && (count_reg == '0);
                        cell_shift     = 1'b1;
                        for (int k = 0; k < PATTERN_MAX; k++)
                        begin
                            cell_load[k] = (CW'(k + 1) == count_reg);
                        end
                        if (in_last && (count_reg != '0))
                        begin
                            mode_next = MODE_DRAIN;
                        end
                    end
                    else
                    begin
                        count_next = newcount;
                        for (int k = 0; k < PATTERN_MAX; k++)
                        begin
                            cell_load[k] = (CW'(k) == count_reg);
                        end
                    end
                end
            end

            MODE_REP:
            begin
                if (space)
                begin
                    push           = 1'b1;
                    push_data.data = rep_arr[rep_idx_reg];
                    push_data.last = rep_last_reg && (rep_left_reg == RW'(1));
                    rep_idx_next   = rep_idx_reg + RIDX'(1);
                    rep_left_next  = rep_left_reg - RW'(1);
                    if (rep_left_reg == RW'(1))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end

            MODE_DRAIN:
            begin
                if (space)
                begin
                    push           = 1'b1;
                    push_data.data = cell_q[0];
                    push_data.last = (count_reg == CW'(1));
                    cell_shift     = 1'b1;
                    count_next     = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
            rep_idx_reg  <= '0;
            rep_left_reg <= '0;
            rep_last_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            rep_idx_reg  <= rep_idx_next;
            rep_left_reg <= rep_left_next;
            rep_last_reg <= rep_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    ssr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_byte   = out_data.data;
    assign byte_valid = out_data.byte_valid;
    assign out_last   = out_data.last;

endmodule

`default_nettype wire
